// ===== design/fvqa_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the flow Q-vector accumulator.
// Depends on nothing; every other file imports it.
package fvqa_pkg;

  localparam int GAP_COUNT       = 4;
  localparam int SINE_TABLE_BITS = 10;
  localparam int ENTRY_COUNT     = 2 * GAP_COUNT;
  localparam int ENTRY_BITS      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int SINE_QUARTER    = 1 << (SINE_TABLE_BITS - 2);
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_BITS      = $clog2(QUEUE_DEPTH);

  localparam int SUM_W  = 48;
  localparam int CNT_W  = 16;
  localparam int DIFF_W = 17;
  localparam int PROD_W = 34;

  localparam logic [1:0] OP_EAST  = 2'd0;
  localparam logic [1:0] OP_WEST  = 2'd1;
  localparam logic [1:0] OP_FULL  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [15:0]        pt_weight_cap;
    logic [15:0]        track_min;
    logic signed [15:0] mean_east_x;
    logic signed [15:0] mean_east_y;
    logic signed [15:0] mean_west_x;
    logic signed [15:0] mean_west_y;
    logic signed [15:0] mean_full_x;
    logic signed [15:0] mean_full_y;
  } cfg_t;

  // Routing information that follows an item through the back end.
  typedef struct packed {
    logic [1:0]            op;
    logic [ENTRY_BITS-1:0] entry;
    logic [ENTRY_BITS-1:0] gap_e;
    logic [ENTRY_BITS-1:0] gap_w;
    logic                  gap_ok;
    logic                  eta_neg;
  } ctl_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    ctl_t                       ctl;
    logic [15:0]                weight;
    logic signed [15:0]         mean_x;
    logic signed [15:0]         mean_y;
    logic [SINE_TABLE_BITS-1:0] idx2;
    logic [SINE_TABLE_BITS-1:0] idx3;
  } q_item_t;

  // sin(pi/2 * t / 65536) in unsigned Q0.15 by an odd degree-9 polynomial in Q30.
  function automatic logic [14:0] quarter_sine(input logic [16:0] t);
    logic [63:0] tt;
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] r;
    tt = 64'(t);
    t2 = (tt * tt) >> 16;
    p  = 64'd172273;
    p  = 64'd5026994 - ((p * t2) >> 16);
    p  = 64'd85569306 - ((p * t2) >> 16);
    p  = 64'd693598667 - ((p * t2) >> 16);
    p  = 64'd1686629713 - ((p * t2) >> 16);
    s  = (p * tt) >> 16;
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[14:0];
  endfunction

  typedef logic [14:0] sine_lut_t [SINE_QUARTER];

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int i = 0; i < SINE_QUARTER; i++) begin
      lut[i] = quarter_sine(17'(i << (18 - SINE_TABLE_BITS)));
    end
    return lut;
  endfunction

  localparam sine_lut_t   SINE_LUT = build_sine_lut();
  // The quarter-turn point itself sits just past the end of the table.
  localparam logic [14:0] SINE_TOP = quarter_sine(17'(65536));

endpackage

// ===== design/fvqa_chan_if.sv =====
// Valid/ready channel interfaces for track items and result items.
// Depends on fvqa_pkg for the sum and count widths.
interface fvqa_item_if import fvqa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [15:0]        phi;
  logic [15:0]        pt;
  logic signed [15:0] eta;
  logic [1:0]         gap_index;

  modport source (output valid, opcode, phi, pt, eta, gap_index, input ready);
  modport sink (input valid, opcode, phi, pt, eta, gap_index, output ready);
endinterface

interface fvqa_result_if import fvqa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] q2x;
  logic signed [SUM_W-1:0] q2y;
  logic signed [SUM_W-1:0] q3x;
  logic signed [SUM_W-1:0] q3y;
  logic [CNT_W-1:0]        track_count;
  logic                    enough_tracks;
  logic [CNT_W-1:0]        full_east_count;
  logic [CNT_W-1:0]        full_west_count;

  modport source (output valid, q2x, q2y, q3x, q3y, track_count, enough_tracks,
                  full_east_count, full_west_count, input ready);
  modport sink (input valid, q2x, q2y, q3x, q3y, track_count, enough_tracks,
                full_east_count, full_west_count, output ready);
endinterface

// ===== design/fvqa_front.sv =====
// Front end: takes track items, works out weight, target entry, mean and angle indices.
// Depends on fvqa_pkg and fvqa_item_if; feeds fvqa_queue.
module fvqa_front import fvqa_pkg::*; (
  fvqa_item_if.sink items,
  input  cfg_t      cfg,
  input  logic      queue_full,
  output logic      push,
  output q_item_t   push_data
);

  logic [15:0] angle2;
  logic [15:0] angle3;

  assign items.ready = !queue_full;
  assign push        = items.valid && !queue_full;

  // Twice and three times the azimuth, wrapped to one turn.
  assign angle2 = {items.phi[14:0], 1'b0};
  assign angle3 = items.phi + angle2;

  always_comb begin
    push_data.ctl.op      = items.opcode;
    push_data.ctl.gap_ok  = int'(items.gap_index) < GAP_COUNT;
    push_data.ctl.gap_e   = ENTRY_BITS'(int'(items.gap_index));
    push_data.ctl.gap_w   = ENTRY_BITS'(int'(items.gap_index) + GAP_COUNT);
    push_data.ctl.entry   = (items.opcode == OP_WEST) ? push_data.ctl.gap_w
                                                      : push_data.ctl.gap_e;
    push_data.ctl.eta_neg = items.eta[15];
    push_data.weight      = (items.pt <= cfg.pt_weight_cap) ? items.pt : cfg.pt_weight_cap;
    case (items.opcode)
      OP_WEST: begin
        push_data.mean_x = cfg.mean_west_x;
        push_data.mean_y = cfg.mean_west_y;
      end
      OP_FULL: begin
        push_data.mean_x = cfg.mean_full_x;
        push_data.mean_y = cfg.mean_full_y;
      end
      default: begin
        push_data.mean_x = cfg.mean_east_x;
        push_data.mean_y = cfg.mean_east_y;
      end
    endcase
    push_data.idx2 = angle2[15 -: SINE_TABLE_BITS];
    push_data.idx3 = angle3[15 -: SINE_TABLE_BITS];
  end

endmodule

// ===== design/fvqa_queue.sv =====
// Short FIFO of classified items between the front and back ends.
// Depends on fvqa_pkg for the entry type and depth.
module fvqa_queue import fvqa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_data,
  output logic    full,
  input  logic    pop,
  output q_item_t pop_data,
  output logic    empty
);

  q_item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_BITS:0]   wr_ptr;
  logic [QUEUE_BITS:0]   rd_ptr;

  assign empty    = (wr_ptr == rd_ptr);
  assign full     = (wr_ptr[QUEUE_BITS] != rd_ptr[QUEUE_BITS]) &&
                    (wr_ptr[QUEUE_BITS-1:0] == rd_ptr[QUEUE_BITS-1:0]);
  assign pop_data = slots[rd_ptr[QUEUE_BITS-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr[QUEUE_BITS-1:0]] <= push_data;
  end

endmodule

// ===== design/fvqa_back.sv =====
// Back end: sine lookup, weight multiply, saturating accumulate and the result register.
// Depends on fvqa_pkg and fvqa_result_if; drains fvqa_queue.
module fvqa_back import fvqa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    queue_empty,
  input  q_item_t queue_data,
  output logic    pop,
  fvqa_result_if.source results
);

  localparam logic [SINE_TABLE_BITS-1:0] QUARTER_IDX = SINE_TABLE_BITS'(SINE_QUARTER);
  localparam logic signed [SUM_W-1:0]   SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]   SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]          CNT_MAX = '1;

  function automatic logic signed [15:0] sine_at(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-2:0] t;
    logic [14:0]                mag;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    t    = {1'b0, idx[SINE_TABLE_BITS-3:0]};
    if (quad[0]) t = (SINE_TABLE_BITS-1)'(SINE_QUARTER) - t;
    mag  = t[SINE_TABLE_BITS-2] ? SINE_TOP : SINE_LUT[t[SINE_TABLE_BITS-3:0]];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [DIFF_W-1:0] centered(input logic signed [15:0] v,
                                                         input logic signed [15:0] m);
    return $signed({v[15], v}) - $signed({m[15], m});
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [PROD_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = $signed({a[SUM_W-1], a}) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) return s[SUM_W] ? SUM_MIN : SUM_MAX;
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  logic advance;
  logic fire;

  // Stage 1: centered sine and cosine terms.
  logic                     v1;
  ctl_t                     s1_ctl;
  logic [15:0]              s1_w;
  logic signed [DIFF_W-1:0] s1_d [4];
  // Stage 2: weighted terms.
  logic                     v2;
  ctl_t                     s2_ctl;
  logic signed [PROD_W-1:0] s2_p [4];
  // Result register.
  logic vo;

  // Event state.
  logic signed [SUM_W-1:0] sub_q [ENTRY_COUNT][4];
  logic signed [SUM_W-1:0] full_q [4];
  logic [CNT_W-1:0]        sub_cnt [ENTRY_COUNT];
  logic [CNT_W-1:0]        full_total;
  logic [CNT_W-1:0]        side_cnt [2];

  logic signed [SUM_W-1:0] sub_q_next [ENTRY_COUNT][4];
  logic signed [SUM_W-1:0] full_q_next [4];
  logic [CNT_W-1:0]        sub_cnt_next [ENTRY_COUNT];
  logic [CNT_W-1:0]        full_total_next;
  logic [CNT_W-1:0]        side_cnt_next [2];
  logic [ENTRY_COUNT-1:0]  above;

  logic signed [SUM_W-1:0] cur [4];
  logic signed [SUM_W-1:0] upd [4];
  logic signed [SUM_W-1:0] res_sum [4];
  logic [CNT_W-1:0]        res_cnt;
  logic                    res_enough;
  logic                    write_sub;
  logic                    write_full;
  logic                    do_clear;

  logic signed [15:0] sin2, cos2, sin3, cos3;

  assign advance       = !vo || results.ready;
  assign pop           = advance && !queue_empty;
  assign fire          = advance && v2;
  assign results.valid = vo;

  assign sin2 = sine_at(queue_data.idx2);
  assign cos2 = sine_at(queue_data.idx2 + QUARTER_IDX);
  assign sin3 = sine_at(queue_data.idx3);
  assign cos3 = sine_at(queue_data.idx3 + QUARTER_IDX);

  always_comb begin
    do_clear   = (s2_ctl.op == OP_CLEAR);
    write_full = (s2_ctl.op == OP_FULL);
    write_sub  = (s2_ctl.op inside {OP_EAST, OP_WEST}) && s2_ctl.gap_ok;

    for (int k = 0; k < 4; k++) begin
      cur[k]         = write_full ? full_q[k] : sub_q[s2_ctl.entry][k];
      upd[k]         = sat_add(cur[k], s2_p[k]);
      full_q_next[k] = do_clear ? '0 : (write_full ? upd[k] : full_q[k]);
      res_sum[k]     = (write_full || write_sub) ? upd[k] : '0;
    end

    for (int e = 0; e < ENTRY_COUNT; e++) begin
      for (int k = 0; k < 4; k++) begin
        if (do_clear) sub_q_next[e][k] = '0;
        else if (write_sub && s2_ctl.entry == ENTRY_BITS'(e)) sub_q_next[e][k] = upd[k];
        else sub_q_next[e][k] = sub_q[e][k];
      end
      if (do_clear) sub_cnt_next[e] = '0;
      else if (write_sub && s2_ctl.entry == ENTRY_BITS'(e)) sub_cnt_next[e] = sat_inc(sub_cnt[e]);
      else sub_cnt_next[e] = sub_cnt[e];
      above[e] = sub_cnt_next[e] > cfg.track_min;
    end

    full_total_next  = do_clear ? '0 : (write_full ? sat_inc(full_total) : full_total);
    side_cnt_next[0] = do_clear ? '0 :
                       ((write_full && s2_ctl.eta_neg) ? sat_inc(side_cnt[0]) : side_cnt[0]);
    side_cnt_next[1] = do_clear ? '0 :
                       ((write_full && !s2_ctl.eta_neg) ? sat_inc(side_cnt[1]) : side_cnt[1]);

    if (write_full) res_cnt = full_total_next;
    else if (write_sub) res_cnt = sub_cnt_next[s2_ctl.entry];
    else res_cnt = '0;

    res_enough = s2_ctl.gap_ok && above[s2_ctl.gap_e] && above[s2_ctl.gap_w];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      vo         <= 1'b0;
      full_total <= '0;
      side_cnt   <= '{default: '0};
      full_q     <= '{default: '0};
      for (int e = 0; e < ENTRY_COUNT; e++) begin
        sub_cnt[e] <= '0;
        sub_q[e]   <= '{default: '0};
      end
    end else begin
      if (advance) begin
        v1 <= !queue_empty;
        v2 <= v1;
        vo <= v2;
      end
      if (fire) begin
        sub_q      <= sub_q_next;
        full_q     <= full_q_next;
        sub_cnt    <= sub_cnt_next;
        full_total <= full_total_next;
        side_cnt   <= side_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl  <= queue_data.ctl;
      s1_w    <= queue_data.weight;
      s1_d[0] <= centered(cos2, queue_data.mean_x);
      s1_d[1] <= centered(sin2, queue_data.mean_y);
      s1_d[2] <= centered(cos3, queue_data.mean_x);
      s1_d[3] <= centered(sin3, queue_data.mean_y);
      s2_ctl  <= s1_ctl;
      for (int k = 0; k < 4; k++) begin
        s2_p[k] <= $signed({1'b0, s1_w}) * s1_d[k];
      end
    end
    if (fire) begin
      results.q2x             <= res_sum[0];
      results.q2y             <= res_sum[1];
      results.q3x             <= res_sum[2];
      results.q3y             <= res_sum[3];
      results.track_count     <= res_cnt;
      results.enough_tracks   <= res_enough;
      results.full_east_count <= side_cnt_next[0];
      results.full_west_count <= side_cnt_next[1];
    end
  end

endmodule

// ===== design/flow_q_vector_accumulator.sv =====
// Each item passes through the queue, stage 1, stage 2 and the result register in that order.
// Throughput: one item per cycle when not stalled; the limit is the last-stage read-add-write.
// Reset (rst, synchronous, active high) zeroes every sum and count, empties the queue and
// pipeline and loads the register defaults (weight cap 2000, track minimum 5, means 0).
// Depends on fvqa_pkg, fvqa_chan_if, fvqa_front, fvqa_queue and fvqa_back.
module flow_q_vector_accumulator import fvqa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fvqa_item_if.sink     items,
  fvqa_result_if.source results
);

  // Register map: register i lives at byte address 4*i.
  localparam logic [2:0] REG_PT_CAP    = 3'd0;
  localparam logic [2:0] REG_TRACK_MIN = 3'd1;
  localparam logic [2:0] REG_EAST_X    = 3'd2;
  localparam logic [2:0] REG_EAST_Y    = 3'd3;
  localparam logic [2:0] REG_WEST_X    = 3'd4;
  localparam logic [2:0] REG_WEST_Y    = 3'd5;
  localparam logic [2:0] REG_FULL_X    = 3'd6;
  localparam logic [2:0] REG_FULL_Y    = 3'd7;

  cfg_t       cfg;
  logic       cfg_write;
  logic [2:0] reg_idx;

  logic    queue_full;
  logic    queue_empty;
  logic    push;
  logic    pop;
  q_item_t push_data;
  q_item_t pop_data;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  // The configuration must only be rewritten while no item is in flight (the block does
  // not enforce this), so that every stage may read it directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pt_weight_cap <= 16'd2000;
      cfg.track_min     <= 16'd5;
      cfg.mean_east_x   <= '0;
      cfg.mean_east_y   <= '0;
      cfg.mean_west_x   <= '0;
      cfg.mean_west_y   <= '0;
      cfg.mean_full_x   <= '0;
      cfg.mean_full_y   <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_PT_CAP:    cfg.pt_weight_cap <= pwdata[15:0];
        REG_TRACK_MIN: cfg.track_min     <= pwdata[15:0];
        REG_EAST_X:    cfg.mean_east_x   <= pwdata[15:0];
        REG_EAST_Y:    cfg.mean_east_y   <= pwdata[15:0];
        REG_WEST_X:    cfg.mean_west_x   <= pwdata[15:0];
        REG_WEST_Y:    cfg.mean_west_y   <= pwdata[15:0];
        REG_FULL_X:    cfg.mean_full_x   <= pwdata[15:0];
        REG_FULL_Y:    cfg.mean_full_y   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Reads return unsigned registers zero-extended and the means sign-extended.
  always_comb begin
    case (reg_idx)
      REG_PT_CAP:    prdata = {16'd0, cfg.pt_weight_cap};
      REG_TRACK_MIN: prdata = {16'd0, cfg.track_min};
      REG_EAST_X:    prdata = 32'(cfg.mean_east_x);
      REG_EAST_Y:    prdata = 32'(cfg.mean_east_y);
      REG_WEST_X:    prdata = 32'(cfg.mean_west_x);
      REG_WEST_Y:    prdata = 32'(cfg.mean_west_y);
      REG_FULL_X:    prdata = 32'(cfg.mean_full_x);
      REG_FULL_Y:    prdata = 32'(cfg.mean_full_y);
      default:       prdata = '0;
    endcase
  end

  // The front end classifies each track as it transfers in and drops it into
  // the queue; the input stays ready as long as the queue has room.
  fvqa_front u_front (
    .items      (items),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // The queue holds up to four items, so the input can keep flowing while the result
  // side is stalled, and the other way round.
  fvqa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  // The back end runs sine lookup, weighting and accumulation as three stages
  // that all move together whenever the result register can take a new value.
  fvqa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .queue_data  (pop_data),
    .pop         (pop),
    .results     (results)
  );

endmodule
